@@ rtl/core/tilt_compass_heading_filter_macros.svh @@
// assertion macros shared by the heading filter rtl
`ifndef TILT_COMPASS_HEADING_FILTER_MACROS_SVH
`define TILT_COMPASS_HEADING_FILTER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define TCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcf_pkg.sv @@
// shared types, constants and the cordic arctangent table
package tcf_pkg;

    localparam int MAG_GAIN     = 766;
    localparam int CORDIC_STEPS = 28;
    localparam int XW           = 36;
    localparam logic [XW-1:0] CORDIC_INV_GAIN = 36'd652032874;

    localparam logic [1:0] REG_SENSORS = 2'd0;
    localparam logic [1:0] REG_BIAS_X  = 2'd1;
    localparam logic [1:0] REG_BIAS_Y  = 2'd2;
    localparam logic [1:0] REG_BIAS_Z  = 2'd3;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic [15:0]        angle;
        logic signed [15:0] sin_q15;
        logic signed [15:0] cos_q15;
    } t_cordic_res;

    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/tilt_compass_heading_filter.sv @@
// top level: apb registers, sequencer, cross product, heading ring and mean
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_raw_mag_x/y/z, i_raw_acc_x/y/z
//  output    out        o_valid / i_ready     o_scaled_mag_*, o_east_*, o_heading, o_heading_updated
//  config    in         apb psel/penable      paddr, pwdata, prdata
//
// with both sensors on, an item passes through three divider runs, a cross product on one
// multiplier, and three 28-step cordic runs plus normalization; with the magnetometer only
// it passes through the divider runs alone, and with neither it goes straight to the output.
// reset is synchronous active low and needs no clearing pass; ring valid bits clear at once.
// o_ready drops for the whole item; a finished result waits in the output register.
module tilt_compass_heading_filter #(
    parameter int FILTER_DEPTH = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_raw_mag_x,
    input  logic signed [15:0] i_raw_mag_y,
    input  logic signed [15:0] i_raw_mag_z,
    input  logic signed [15:0] i_raw_acc_x,
    input  logic signed [15:0] i_raw_acc_y,
    input  logic signed [15:0] i_raw_acc_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_scaled_mag_x,
    output logic signed [15:0] o_scaled_mag_y,
    output logic signed [15:0] o_scaled_mag_z,
    output logic signed [32:0] o_east_x,
    output logic signed [32:0] o_east_y,
    output logic signed [32:0] o_east_z,
    output logic [15:0]        o_heading,
    output logic               o_heading_updated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tcf_pkg::*;

    `include "tilt_compass_heading_filter_macros.svh"

    localparam int PW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SW = $clog2(FILTER_DEPTH + 1) + 16;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_CROSS, S_VEC1, S_ROT, S_VEC2, S_DONE} t_state;

    // configuration
    logic [1:0]  r_en;
    logic [14:0] r_bias_x;
    logic [14:0] r_bias_y;
    logic [14:0] r_bias_z;

    // sequencer and held values
    t_state             r_state;
    logic signed [15:0] r_raw [3];
    logic signed [15:0] r_mag [3];
    logic signed [15:0] r_acc [3];
    logic signed [32:0] r_east [3];
    logic [15:0]        r_heading;
    logic               r_upd;
    logic [1:0]         r_axis;
    logic [2:0]         r_cnt;
    logic signed [31:0] r_prod;
    logic               r_div_start;
    t_cordic_req        r_creq;
    logic signed [XW-1:0] r_cx;
    logic signed [XW-1:0] r_cy;
    logic [15:0]        r_ca;
    logic signed [SW-1:0] r_ssum;
    logic signed [SW-1:0] r_csum;
    logic [PW-1:0]      r_pos;
    logic [FILTER_DEPTH-1:0] r_vld;

    // ring memory
    logic signed [15:0] r_smem [FILTER_DEPTH];
    logic signed [15:0] r_cmem [FILTER_DEPTH];
    logic signed [15:0] r_rd_s;
    logic signed [15:0] r_rd_c;

    // output register
    logic               r_o_valid;
    logic signed [15:0] r_o_mag [3];
    logic signed [32:0] r_o_east [3];
    logic [15:0]        r_o_heading;
    logic               r_o_upd;

    logic               w_div_done;
    logic signed [15:0] w_div_q;
    logic signed [25:0] w_div_p;
    logic [14:0]        w_div_d;
    t_cordic_res        w_cres;
    logic signed [15:0] w_ma;
    logic signed [15:0] w_mb;
    logic [2:0]         w_idx;
    logic signed [15:0] w_old_s;
    logic signed [15:0] w_old_c;
    logic signed [SW-1:0] w_nssum;
    logic signed [SW-1:0] w_ncsum;
    logic               w_we;
    logic               w_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 2'd0;
            r_bias_x <= 15'd766;
            r_bias_y <= 15'd766;
            r_bias_z <= 15'd713;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_SENSORS: r_en     <= pwdata[1:0];
                REG_BIAS_X:  r_bias_x <= pwdata[14:0];
                REG_BIAS_Y:  r_bias_y <= pwdata[14:0];
                REG_BIAS_Z:  r_bias_z <= pwdata[14:0];
                default:     r_en     <= r_en;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SENSORS: prdata = {30'd0, r_en};
            REG_BIAS_X:  prdata = {17'd0, r_bias_x};
            REG_BIAS_Y:  prdata = {17'd0, r_bias_y};
            REG_BIAS_Z:  prdata = {17'd0, r_bias_z};
            default:     prdata = 32'd0;
        endcase
    end

    // ---------------- shared units ----------------
    always_comb begin
        case (r_axis)
            2'd0:    w_div_d = r_bias_x;
            2'd1:    w_div_d = r_bias_y;
            default: w_div_d = r_bias_z;
        endcase
    end

    assign w_div_p = 26'(r_raw[r_axis]) * 26'sd766;

    tcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_p     (w_div_p),
        .i_div   (w_div_d),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    tcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_creq),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .i_angle (r_ca),
        .o_res   (w_cres)
    );

    // cross product operand order: my*az, mz*ay, mz*ax, mx*az, mx*ay, my*ax
    always_comb begin
        case (r_cnt)
            3'd0:    begin w_ma = r_mag[1]; w_mb = r_acc[2]; end
            3'd1:    begin w_ma = r_mag[2]; w_mb = r_acc[1]; end
            3'd2:    begin w_ma = r_mag[2]; w_mb = r_acc[0]; end
            3'd3:    begin w_ma = r_mag[0]; w_mb = r_acc[2]; end
            3'd4:    begin w_ma = r_mag[0]; w_mb = r_acc[1]; end
            3'd5:    begin w_ma = r_mag[1]; w_mb = r_acc[0]; end
            default: begin w_ma = 16'sd0;   w_mb = 16'sd0;   end
        endcase
    end

    assign w_idx = r_cnt - 3'd1;

    // running ring sums: drop the entry being replaced, add the new one
    assign w_old_s = r_vld[r_pos] ? r_rd_s : 16'sd0;
    assign w_old_c = r_vld[r_pos] ? r_rd_c : 16'sd0;
    assign w_nssum = r_ssum - SW'(w_old_s) + SW'(w_cres.sin_q15);
    assign w_ncsum = r_csum - SW'(w_old_c) + SW'(w_cres.cos_q15);
    assign w_we    = (r_state == S_ROT) && w_cres.done;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_smem[r_pos] <= w_cres.sin_q15;
            r_cmem[r_pos] <= w_cres.cos_q15;
        end
        r_rd_s <= r_smem[r_pos];
        r_rd_c <= r_cmem[r_pos];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_creq      <= '0;
            r_axis      <= '0;
            r_cnt       <= '0;
            r_mag       <= '{default: '0};
            r_acc       <= '{default: '0};
            r_east      <= '{default: '0};
            r_heading   <= '0;
            r_upd       <= 1'b0;
            r_ssum      <= '0;
            r_csum      <= '0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start  <= 1'b0;
            r_creq.start <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_raw[0] <= i_raw_mag_x;
                        r_raw[1] <= i_raw_mag_y;
                        r_raw[2] <= i_raw_mag_z;
                        r_upd    <= 1'b0;
                        if (r_en[1]) begin
                            r_acc[0] <= i_raw_acc_x;
                            r_acc[1] <= i_raw_acc_y;
                            r_acc[2] <= i_raw_acc_z;
                        end
                        if (r_en[0]) begin
                            r_axis      <= 2'd0;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mag[r_axis] <= w_div_q;
                        if (r_axis == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= r_en[1] ? S_CROSS : S_DONE;
                        end else begin
                            r_axis      <= r_axis + 2'd1;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_CROSS: begin
                    r_prod <= w_ma * w_mb;
                    // even slot loads a component, odd slot subtracts the second product
                    if (r_cnt != 3'd0) begin
                        if (w_idx[0]) begin
                            r_east[w_idx[2:1]] <= r_east[w_idx[2:1]] - 33'(r_prod);
                        end else begin
                            r_east[w_idx[2:1]] <= 33'(r_prod);
                        end
                    end
                    if (r_cnt == 3'd6) begin
                        r_cx    <= XW'(r_east[0]);
                        r_cy    <= XW'(r_east[1]);
                        r_creq  <= '{start: 1'b1, rotate: 1'b0};
                        r_state <= S_VEC1;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_VEC1: begin
                    if (w_cres.done) begin
                        r_ca    <= w_cres.angle;
                        r_creq  <= '{start: 1'b1, rotate: 1'b1};
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (w_cres.done) begin
                        r_ssum       <= w_nssum;
                        r_csum       <= w_ncsum;
                        r_vld[r_pos] <= 1'b1;
                        r_pos        <= (r_pos == PW'(FILTER_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                        r_cx         <= XW'(w_ncsum);
                        r_cy         <= XW'(w_nssum);
                        r_creq       <= '{start: 1'b1, rotate: 1'b0};
                        r_state      <= S_VEC2;
                    end
                end
                S_VEC2: begin
                    if (w_cres.done) begin
                        r_heading <= w_cres.angle;
                        r_upd     <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_mag     <= r_mag;
                        r_o_east    <= r_east;
                        r_o_heading <= r_heading;
                        r_o_upd     <= r_upd;
                        r_o_valid   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_scaled_mag_x    = r_o_mag[0];
    assign o_scaled_mag_y    = r_o_mag[1];
    assign o_scaled_mag_z    = r_o_mag[2];
    assign o_east_x          = r_o_east[0];
    assign o_east_y          = r_o_east[1];
    assign o_east_z          = r_o_east[2];
    assign o_heading         = r_o_heading;
    assign o_heading_updated = r_o_upd;

    `TCF_ASSERT_NXT(a_busy_after_transfer, i_valid && o_ready, !o_ready,
        "input accepted while an item is in flight")
    `TCF_ASSERT_IMP(a_ring_pos_range, 1'b1, 32'(r_pos) < FILTER_DEPTH,
        "ring position beyond filter depth")
    `TCF_ASSERT_IMP(a_updated_needs_both, o_valid && o_heading_updated, r_en == 2'b11,
        "heading marked updated without both sensors enabled")
    `TCF_ASSERT_IMP(a_cordic_start_state, r_creq.start,
        r_state == S_VEC1 || r_state == S_ROT || r_state == S_VEC2,
        "cordic started outside an angle phase")

endmodule

@@ rtl/core/tcf_div.sv @@
// bit-serial restoring divider for magnetometer axis scaling, with saturation
module tcf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [25:0] i_p,
    input  logic [14:0]        i_div,
    output logic               o_done,
    output logic signed [15:0] o_q
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [14:0] r_rem;
    logic [24:0] r_num;
    logic [24:0] r_q;
    logic [14:0] r_div;
    logic        r_neg;
    logic        r_pzero;
    logic        r_dzero;
    logic [25:0] w_mag;
    logic [15:0] w_trial;
    logic        w_fit;

    assign w_mag   = i_p[25] ? 26'(-i_p) : 26'(i_p);
    assign w_trial = {r_rem, r_num[24]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_num   <= w_mag[24:0];
                r_q     <= '0;
                r_div   <= i_div;
                r_neg   <= i_p[25];
                r_pzero <= (i_p == '0);
                r_dzero <= (i_div == '0);
            end else if (r_busy) begin
                r_rem <= w_fit ? 15'(w_trial - {1'b0, r_div}) : w_trial[14:0];
                r_num <= {r_num[23:0], 1'b0};
                r_q   <= {r_q[23:0], w_fit};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd24) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_dzero) begin
            o_q = r_pzero ? 16'sd0 : (r_neg ? -16'sd32768 : 16'sd32767);
        end else if (r_neg) begin
            o_q = (r_q > 25'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, r_q}));
        end else begin
            o_q = (r_q > 25'd32767) ? 16'sd32767 : $signed(r_q[15:0]);
        end
    end

    assign o_done = r_done;

endmodule

@@ rtl/core/tcf_cordic.sv @@
// shared cordic: vectoring gives a 16-bit angle, rotation gives q1.15 sine and cosine
module tcf_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcf_pkg::t_cordic_req            i_req,
    input  logic signed [tcf_pkg::XW-1:0]   i_x,
    input  logic signed [tcf_pkg::XW-1:0]   i_y,
    input  logic [15:0]                     i_angle,
    output tcf_pkg::t_cordic_res            o_res
);
    import tcf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_NORM, S_ITER} t_state;

    t_state               r_state;
    logic                 r_rotate;
    logic                 r_done;
    logic [4:0]           r_i;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic [31:0]          r_z;
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [XW-1:0] w_ay;
    logic signed [XW-1:0] w_m;
    logic                 w_sub;
    logic [31:0]          w_z0;
    logic [31:0]          w_zr;
    logic signed [XW-1:0] w_sx;
    logic signed [XW-1:0] w_sy;

    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_ay  = r_y[XW-1] ? -r_y : r_y;
    assign w_m   = (r_x > w_ay) ? r_x : w_ay;
    assign w_sub = r_rotate ? !r_z[31] : r_y[XW-1];
    assign w_z0  = {i_angle, 16'h0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_rotate <= i_req.rotate;
                        r_i      <= '0;
                        if (i_req.rotate) begin
                            // second and third quadrant start from the negative axis
                            if (i_angle[15] != i_angle[14]) begin
                                r_x <= -$signed(CORDIC_INV_GAIN);
                                r_z <= w_z0 ^ 32'h80000000;
                            end else begin
                                r_x <= $signed(CORDIC_INV_GAIN);
                                r_z <= w_z0;
                            end
                            r_y     <= '0;
                            r_state <= S_ITER;
                        end else if (i_x == '0 && i_y == '0) begin
                            r_z    <= '0;
                            r_done <= 1'b1;
                        end else if (i_x[XW-1]) begin
                            r_x     <= -i_x;
                            r_y     <= -i_y;
                            r_z     <= 32'h80000000;
                            r_state <= S_NORM;
                        end else begin
                            r_x     <= i_x;
                            r_y     <= i_y;
                            r_z     <= '0;
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // bring the larger magnitude up to 2^30, eight bits at a time when far below
                    if (w_m[XW-1:30] != '0) begin
                        r_state <= S_ITER;
                    end else if (w_m[XW-1:22] == '0) begin
                        r_x <= r_x <<< 8;
                        r_y <= r_y <<< 8;
                    end else begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end
                end
                S_ITER: begin
                    if (w_sub) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - f_atan(r_i);
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + f_atan(r_i);
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // round to q1.15 with floor, then saturate
    assign w_sx = (r_x + XW'(16384)) >>> 15;
    assign w_sy = (r_y + XW'(16384)) >>> 15;
    assign w_zr = r_z + 32'h00008000;

    always_comb begin
        o_res.done  = r_done;
        o_res.angle = w_zr[31:16];
        if (w_sy > XW'(32767))       o_res.sin_q15 = 16'sd32767;
        else if (w_sy < -XW'(32768)) o_res.sin_q15 = -16'sd32768;
        else                         o_res.sin_q15 = w_sy[15:0];
        if (w_sx > XW'(32767))       o_res.cos_q15 = 16'sd32767;
        else if (w_sx < -XW'(32768)) o_res.cos_q15 = -16'sd32768;
        else                         o_res.cos_q15 = w_sx[15:0];
    end

endmodule
